// File: rtl/best_fit_heap_allocator_defines.svh
// assertion macros shared by the allocator checks
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// implication checked only outside reset
`define BFHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, also checked across reset
`define BFHA_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: rtl/bfha_pkg.sv
// constants and types of the best-fit heap allocator
package bfha_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;
  localparam int GRAN         = POOL_BYTES / 8;
  localparam int HDR          = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int POOL_USED    = GRAN * 8;
  localparam int GW           = $clog2(GRAN);
  localparam int CW           = GW + 1;
  localparam int BW           = 12;
  localparam int AW           = $clog2(POOL_USED) + 2;
  localparam int SW           = 3;
  localparam int NW           = 32;
  localparam logic [NW-1:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [SW-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_BADADDR = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_t;

  typedef struct packed {
    logic          is_start;
    logic          in_use;
    logic [BW-1:0] bytes;
    logic [BW-1:0] left;
  } map_rd_t;

  typedef struct packed {
    logic [GW-1:0] addr;
    logic          we_start;
    logic          we_use;
    logic          we_bytes;
    logic          we_left;
    logic          is_start;
    logic          in_use;
    logic [BW-1:0] bytes;
    logic [BW-1:0] left;
  } map_wr_t;

endpackage

// File: rtl/bfha_if.sv
// request and result channel interfaces
interface bfha_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [bfha_pkg::BW-1:0]  req_bytes;
  logic [bfha_pkg::BW-1:0]  free_offset;
  modport source (output valid, req_type, req_bytes, free_offset, input ready);
  modport sink (input valid, req_type, req_bytes, free_offset, output ready);
endinterface

interface bfha_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [bfha_pkg::SW-1:0]  status;
  logic [bfha_pkg::BW-1:0]  data_offset;
  logic [bfha_pkg::BW-1:0]  granted_bytes;
  logic [bfha_pkg::NW-1:0]  alloc_count;
  logic [bfha_pkg::NW-1:0]  free_count;
  modport source (output valid, status, data_offset, granted_bytes, alloc_count,
                  free_count, input ready);
  modport sink (input valid, status, data_offset, granted_bytes, alloc_count,
                free_count, output ready);
endinterface

// File: rtl/best_fit_heap_allocator.sv
// best-fit heap allocator top level: sequencer over the block map
//
//  channel  dir  fields
//  req      in   req_type, req_bytes, free_offset
//  rsp      out  status, data_offset, granted_bytes, alloc_count, free_count
//
// allocate: scans all 512 map entries through the single map read port;
// free: reads the block, then its left and right neighbours, merging free ones
// after reset a clearing pass over all 512 map entries runs before the first item
// a finished result waits in the output register; the next item is taken
// meanwhile, and the sequencer holds only if a second result is ready
module best_fit_heap_allocator (
  input logic        clk,
  input logic        rst,
  bfha_req_if.sink   req,
  bfha_rsp_if.source rsp
);
  import bfha_pkg::*;

  typedef enum logic [16:0] {
    S_CLR    = 17'h00001,
    S_IDLE   = 17'h00002,
    S_SCAN   = 17'h00004,
    S_A_DEC  = 17'h00008,
    S_A_W1   = 17'h00010,
    S_A_W2   = 17'h00020,
    S_A_NXT  = 17'h00040,
    S_F_RD   = 17'h00080,
    S_F_CHK  = 17'h00100,
    S_F_LRD  = 17'h00200,
    S_F_LCHK = 17'h00400,
    S_F_LCLR = 17'h00800,
    S_F_RRD  = 17'h01000,
    S_F_RCHK = 17'h02000,
    S_F_RCLR = 17'h04000,
    S_F_NXT  = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  localparam logic [AW-1:0] HDR_A  = AW'(HDR);
  localparam logic [AW-1:0] POOL_A = AW'(POOL_USED);
  localparam logic [BW-1:0] INIT_BYTES = BW'(POOL_USED - HDR);

  state_t        state;
  logic [CW-1:0] cnt;
  logic [AW-1:0] need;
  logic [AW-1:0] hdr;
  logic [GW-1:0] g;
  logic [GW-1:0] oldg;
  logic [GW-1:0] tgt;
  logic [AW-1:0] nxt;
  logic [AW-1:0] cur;
  logic [BW-1:0] lval;
  logic [BW-1:0] left;
  logic          cand;
  logic          split;
  logic          found;
  logic [GW-1:0] best;
  logic [BW-1:0] best_bytes;
  logic [NW-1:0] allocations_done;
  logic [NW-1:0] frees_done;
  status_t       res_status;
  logic [BW-1:0] res_off;
  logic [BW-1:0] res_bytes;
  logic          out_valid;
  status_t       out_status;
  logic [BW-1:0] out_off;
  logic [BW-1:0] out_bytes;
  logic [NW-1:0] out_allocs;
  logic [NW-1:0] out_frees;

  logic [GW-1:0] rd_addr;
  map_wr_t       wr;
  map_rd_t       rd;

  // shared address and size arithmetic
  logic [AW-1:0] off_a;
  logic [AW-1:0] off_hdr;
  logic [AW-1:0] rd_bytes_a;
  logic [AW-1:0] lh;
  logic [AW-1:0] rh;
  logic [AW-1:0] sum;
  logic [AW-1:0] need_a;
  logic [GW-1:0] sidx;
  logic          fits;

  assign off_a      = AW'(req.free_offset);
  assign off_hdr    = off_a - HDR_A;
  assign rd_bytes_a = AW'(rd.bytes);
  assign lh         = hdr - HDR_A - AW'(left);
  assign rh         = hdr + HDR_A + cur;
  assign sum        = rd_bytes_a + HDR_A + cur;
  assign need_a     = (AW'(req.req_bytes) + AW'(7)) & ~AW'(7);
  assign sidx       = cnt[GW-1:0] - GW'(1);
  assign fits       = rd.is_start && !rd.in_use && (rd_bytes_a >= need) &&
                      (!found || rd.bytes < best_bytes);

  bfha_map u_map (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  // granule of the split-off block header
  function automatic logic [GW-1:0] sum_ng(input logic [AW-1:0] h, input logic [AW-1:0] n);
    logic [AW-1:0] s;
    s = h + HDR_A + n;
    return s[GW+2:3];
  endfunction

  // map read address
  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = cnt[GW-1:0];
      S_F_LRD: rd_addr = lh[GW+2:3];
      S_F_RRD: rd_addr = rh[GW+2:3];
      default: rd_addr = g;
    endcase
  end

  // map write port
  always_comb begin
    wr = '0;
    unique case (state)
      S_CLR: begin
        wr.addr     = cnt[GW-1:0];
        wr.we_start = 1'b1;
        wr.we_use   = 1'b1;
        wr.we_bytes = 1'b1;
        wr.we_left  = 1'b1;
        wr.is_start = (cnt == '0);
        wr.bytes    = (cnt == '0) ? INIT_BYTES : '0;
      end
      S_A_W1: begin
        wr.addr     = best;
        wr.we_use   = 1'b1;
        wr.in_use   = 1'b1;
        wr.we_bytes = split;
        wr.bytes    = need[BW-1:0];
      end
      S_A_W2: begin
        wr.addr     = tgt;
        wr.we_start = cand;
        wr.we_use   = cand;
        wr.we_bytes = cand;
        wr.we_left  = cand;
        wr.is_start = 1'b1;
        wr.bytes    = lval;
        wr.left     = need[BW-1:0];
      end
      S_A_NXT: begin
        wr.addr    = nxt[GW+2:3];
        wr.we_left = cand && (nxt < POOL_A);
        wr.left    = lval;
      end
      S_F_CHK: begin
        wr.addr   = g;
        wr.we_use = rd.is_start && rd.in_use;
      end
      S_F_LCHK: begin
        wr.addr     = tgt;
        wr.we_bytes = cand && rd.is_start && !rd.in_use && rd.bytes == left;
        wr.bytes    = sum[BW-1:0];
      end
      S_F_LCLR: begin
        wr.addr     = oldg;
        wr.we_start = 1'b1;
      end
      S_F_RCHK: begin
        wr.addr     = g;
        wr.we_bytes = cand && rd.is_start && rd.left != '0 && !rd.in_use;
        wr.bytes    = sum[BW-1:0];
      end
      S_F_RCLR: begin
        wr.addr     = tgt;
        wr.we_start = 1'b1;
      end
      S_F_NXT: begin
        wr.addr    = rh[GW+2:3];
        wr.we_left = rh < POOL_A;
        wr.left    = cur[BW-1:0];
      end
      default: wr = '0;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      cnt              <= '0;
      out_valid        <= 1'b0;
      allocations_done <= '0;
      frees_done       <= '0;
      found            <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(GRAN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            res_off   <= '0;
            res_bytes <= '0;
            if (req.req_type) begin
              hdr <= off_hdr;
              g   <= off_hdr[GW+2:3];
              if (off_a < HDR_A || off_hdr[2:0] != 3'd0 || off_hdr >= POOL_A) begin
                res_status <= ST_BADADDR;
                state      <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end else if (req.req_bytes == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              need  <= need_a;
              cnt   <= '0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt != '0 && fits) begin
            found      <= 1'b1;
            best       <= sidx;
            best_bytes <= rd.bytes;
          end
          if (cnt == CW'(GRAN)) state <= S_A_DEC;
        end
        S_A_DEC: begin
          if (!found) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            hdr   <= AW'({best, 3'b000});
            split <= AW'(best_bytes) > need + HDR_A + AW'(8);
            nxt   <= AW'({best, 3'b000}) + HDR_A + AW'(best_bytes);
            state <= S_A_W1;
          end
        end
        S_A_W1: begin
          tgt  <= sum_ng(hdr, need);
          cand <= split ? ((hdr + HDR_A + need) < POOL_A) : 1'b1;
          if (split) begin
            lval  <= best_bytes - need[BW-1:0] - BW'(HDR);
            state <= S_A_W2;
          end else begin
            lval  <= best_bytes;
            state <= S_A_NXT;
          end
        end
        S_A_W2: state <= S_A_NXT;
        S_A_NXT: begin
          if (allocations_done != CNT_MAX) allocations_done <= allocations_done + NW'(1);
          res_status <= ST_OK;
          res_off    <= BW'(hdr + HDR_A);
          res_bytes  <= split ? need[BW-1:0] : best_bytes;
          state      <= S_DONE;
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (!rd.is_start) begin
            res_status <= ST_BADADDR;
            state      <= S_DONE;
          end else if (!rd.in_use) begin
            res_status <= ST_DOUBLE;
            state      <= S_DONE;
          end else begin
            if (frees_done != CNT_MAX) frees_done <= frees_done + NW'(1);
            cur   <= rd_bytes_a;
            left  <= rd.left;
            state <= S_F_LRD;
          end
        end
        S_F_LRD: begin
          cand  <= left != '0 && hdr >= HDR_A + AW'(left) && lh[2:0] == 3'd0;
          tgt   <= lh[GW+2:3];
          state <= S_F_LCHK;
        end
        S_F_LCHK: begin
          if (cand && rd.is_start && !rd.in_use && rd.bytes == left) begin
            cur   <= sum;
            oldg  <= g;
            g     <= tgt;
            hdr   <= lh;
            state <= S_F_LCLR;
          end else begin
            state <= S_F_RRD;
          end
        end
        S_F_LCLR: state <= S_F_RRD;
        S_F_RRD: begin
          cand  <= rh < POOL_A;
          tgt   <= rh[GW+2:3];
          state <= S_F_RCHK;
        end
        S_F_RCHK: begin
          if (cand && rd.is_start && rd.left != '0 && !rd.in_use) begin
            cur   <= sum;
            state <= S_F_RCLR;
          end else begin
            state <= S_F_NXT;
          end
        end
        S_F_RCLR: state <= S_F_NXT;
        S_F_NXT: begin
          res_status <= ST_OK;
          res_off    <= BW'(hdr + HDR_A);
          res_bytes  <= cur[BW-1:0];
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_off    <= res_off;
      out_bytes  <= res_bytes;
      out_allocs <= allocations_done;
      out_frees  <= frees_done;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.data_offset   = out_off;
  assign rsp.granted_bytes = out_bytes;
  assign rsp.alloc_count   = out_allocs;
  assign rsp.free_count    = out_frees;

endmodule

// File: rtl/bfha_map.sv
// block map memories, one entry per granule, registered read
module bfha_map (
  input  logic              clk,
  input  logic [bfha_pkg::GW-1:0] rd_addr,
  input  bfha_pkg::map_wr_t wr,
  output bfha_pkg::map_rd_t rd
);
  import bfha_pkg::*;

  logic          start_mem [GRAN];
  logic          use_mem   [GRAN];
  logic [BW-1:0] bytes_mem [GRAN];
  logic [BW-1:0] left_mem  [GRAN];

  // per-field write ports
  always_ff @(posedge clk) begin
    if (wr.we_start) start_mem[wr.addr] <= wr.is_start;
    if (wr.we_use)   use_mem[wr.addr]   <= wr.in_use;
    if (wr.we_bytes) bytes_mem[wr.addr] <= wr.bytes;
    if (wr.we_left)  left_mem[wr.addr]  <= wr.left;
  end

  // registered read
  always_ff @(posedge clk) begin
    rd.is_start <= start_mem[rd_addr];
    rd.in_use   <= use_mem[rd_addr];
    rd.bytes    <= bytes_mem[rd_addr];
    rd.left     <= left_mem[rd_addr];
  end

endmodule

// File: rtl/bfha_checker.sv
// port-level checks of the allocator, bound to the top level
`include "best_fit_heap_allocator_defines.svh"

module bfha_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [bfha_pkg::SW-1:0] status,
  input logic [bfha_pkg::BW-1:0] data_offset,
  input logic [bfha_pkg::BW-1:0] granted_bytes
);
  import bfha_pkg::*;

  // clearing pass holds off items right after reset
  `BFHA_ASSERT_NEXT(a_clear_after_reset, clk, rst, !req_ready)
  // an error result carries no block
  `BFHA_ASSERT_IMPL(a_error_empty, clk, rst, rsp_valid && status != ST_OK,
    data_offset == '0 && granted_bytes == '0)
  // a granted data area always lies past one header and has a size that is a multiple of 8
  `BFHA_ASSERT_IMPL(a_ok_past_header, clk, rst, rsp_valid && status == ST_OK,
    data_offset >= BW'(HDR) && granted_bytes[2:0] == 3'd0)
  // a waiting result stays offered
  `BFHA_ASSERT_NEXT(a_rsp_hold, clk, !rst && rsp_valid && !rsp_ready, rst || rsp_valid)

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .data_offset   (rsp.data_offset),
  .granted_bytes (rsp.granted_bytes)
);

// File: tb/bfha_checker.sv
// result checker: follows the allocator's block map and compares every result item
`timescale 1ns / 100ps

module bfha_result_checker (
  input  logic       clk,
  input  logic       rst,
  bfha_req_if        req,
  bfha_rsp_if        rsp,
  output int         fail_count,
  output int         pending
);
  import bfha_pkg::*;

  typedef struct {
    status_t       status;
    logic [BW-1:0] data_offset;
    logic [BW-1:0] granted_bytes;
    logic [NW-1:0] alloc_count;
    logic [NW-1:0] free_count;
  } outcome_t;

  // shadow block map, indexed by header offset / 8
  bit             map_start [GRAN];
  bit             map_used  [GRAN];
  int unsigned    map_bytes [GRAN];
  int unsigned    map_left  [GRAN];
  logic [NW-1:0]  allocs_seen;
  logic [NW-1:0]  frees_seen;
  outcome_t       expected_q[$];

  function automatic void clear_map();
    for (int i = 0; i < GRAN; i++) begin
      map_start[i] = 0;
      map_used[i]  = 0;
      map_bytes[i] = 0;
      map_left[i]  = 0;
    end
    map_start[0] = 1;
    map_bytes[0] = POOL_USED - HDR;
    allocs_seen  = '0;
    frees_seen   = '0;
  endfunction

  // record this block's size in the block that follows it
  function automatic void link_next(int unsigned hdr);
    int unsigned nxt;
    nxt = hdr + HDR + map_bytes[hdr / 8];
    if (nxt < POOL_USED) map_left[nxt / 8] = map_bytes[hdr / 8];
  endfunction

  function automatic outcome_t make_outcome(status_t st, int unsigned off, int unsigned sz);
    outcome_t o;
    o.status        = st;
    o.data_offset   = off[BW-1:0];
    o.granted_bytes = sz[BW-1:0];
    o.alloc_count   = allocs_seen;
    o.free_count    = frees_seen;
    return o;
  endfunction

  // best fit: smallest free block that holds the rounded size, lowest offset on ties
  function automatic outcome_t grant_block(int unsigned asked);
    int unsigned need, best, orig, hdr, nh, ng;
    bit found;
    found = 0;
    best  = 0;
    if (asked == 0) return make_outcome(ST_ZERO, 0, 0);
    need = (asked + 7) & ~32'd7;
    for (int i = 0; i < GRAN; i++) begin
      if (map_start[i] && !map_used[i] && map_bytes[i] >= need) begin
        if (!found || map_bytes[i] < map_bytes[best]) begin
          best  = i;
          found = 1;
        end
      end
    end
    if (!found) return make_outcome(ST_NOFIT, 0, 0);
    hdr  = best * 8;
    orig = map_bytes[best];
    map_used[best] = 1;
    if (orig > need + HDR + 8) begin
      nh = hdr + HDR + need;
      ng = nh / 8;
      map_bytes[best] = need;
      if (ng < GRAN) begin
        map_start[ng] = 1;
        map_used[ng]  = 0;
        map_bytes[ng] = orig - need - HDR;
        map_left[ng]  = need;
        link_next(nh);
      end
    end else begin
      link_next(hdr);
    end
    if (allocs_seen != CNT_MAX) allocs_seen++;
    return make_outcome(ST_OK, hdr + HDR, map_bytes[best]);
  endfunction

  // release with merging into free left and right neighbors
  function automatic outcome_t release_block(int unsigned off);
    int unsigned hdr, g, lsz, lh, lg, rh, rg;
    if (off < HDR) return make_outcome(ST_BADADDR, 0, 0);
    hdr = off - HDR;
    if ((hdr & 7) != 0 || hdr >= POOL_USED || !map_start[hdr / 8])
      return make_outcome(ST_BADADDR, 0, 0);
    g = hdr / 8;
    if (!map_used[g]) return make_outcome(ST_DOUBLE, 0, 0);
    if (frees_seen != CNT_MAX) frees_seen++;
    map_used[g] = 0;
    lsz = map_left[g];
    if (lsz > 0 && hdr >= HDR + lsz) begin
      lh = hdr - HDR - lsz;
      lg = lh / 8;
      if ((lh & 7) == 0 && map_start[lg] && !map_used[lg] && map_bytes[lg] == lsz) begin
        map_bytes[lg] += HDR + map_bytes[g];
        map_start[g] = 0;
        hdr = lh;
        g   = lg;
      end
    end
    rh = hdr + HDR + map_bytes[g];
    if (rh < POOL_USED) begin
      rg = rh / 8;
      if (map_start[rg] && map_left[rg] != 0 && !map_used[rg]) begin
        map_bytes[g] += HDR + map_bytes[rg];
        map_start[rg] = 0;
      end
    end
    link_next(hdr);
    return make_outcome(ST_OK, hdr + HDR, map_bytes[g]);
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_map();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result item with nothing expected, status %0d", $time, rsp.status);
        end else begin
          want = expected_q.pop_front();
          if (rsp.status !== want.status || rsp.data_offset !== want.data_offset ||
              rsp.granted_bytes !== want.granted_bytes ||
              rsp.alloc_count !== want.alloc_count || rsp.free_count !== want.free_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                       $time, want.status, want.data_offset, want.granted_bytes,
                       want.alloc_count, want.free_count, rsp.status, rsp.data_offset,
                       rsp.granted_bytes, rsp.alloc_count, rsp.free_count);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type) want = release_block(req.free_offset);
        else              want = grant_block(req.req_bytes);
        expected_q.insert(expected_q.size(), want);
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/best_fit_heap_allocator_test.sv
// stimulus, reset, watchdog and verdict for the best-fit heap allocator
`timescale 1ns / 100ps

module best_fit_heap_allocator_test;
  import bfha_pkg::*;

  localparam int ITEMS      = 1000;
  localparam int HOLD_LEN   = 3000;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 600;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   phase;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_wanted;
  int   quiet_cycles;
  bit   kind_q[$];
  logic [BW-1:0] live_q[$];
  logic [BW-1:0] freed_q[$];

  bfha_req_if req_ch();
  bfha_rsp_if rsp_ch();

  best_fit_heap_allocator dut (.clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source));

  bfha_result_checker chk (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
                           .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one item, hold it until taken, then maybe leave a gap
  task automatic send_item(bit kind, int unsigned nbytes, int unsigned off);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.req_bytes   <= nbytes[BW-1:0];
    req_ch.free_offset <= off[BW-1:0];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    kind_q.insert(kind_q.size(), kind);
    sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // random mix of allocations and frees of live, stale and arbitrary offsets
  task automatic send_random();
    int pick, idx;
    pick = $urandom_range(99);
    if (pick < 50) begin
      pick = $urandom_range(99);
      if (pick < 80)      send_item(1'b0, $urandom_range(128, 1), 0);
      else if (pick < 95) send_item(1'b0, $urandom_range(1024, 0), 0);
      else                send_item(1'b0, $urandom_range(4095, 0), 0);
    end else if (pick < 85 && live_q.size() > 0) begin
      idx = $urandom_range(live_q.size() - 1);
      freed_q.insert(freed_q.size(), live_q[idx]);
      send_item(1'b1, $urandom, live_q[idx]);
      live_q.delete(idx);
    end else if (pick < 92 && freed_q.size() > 0) begin
      send_item(1'b1, $urandom, freed_q[$urandom_range(freed_q.size() - 1)]);
    end else begin
      send_item(1'b1, $urandom, $urandom_range(4095, 0));
    end
  endtask

  // keep track of granted offsets for later frees
  always @(posedge clk) begin
    bit kind;
    if (!rst && rsp_ch.valid && rsp_ch.ready && kind_q.size() > 0) begin
      kind = kind_q.pop_front();
      if (!kind && rsp_ch.status == ST_OK) live_q.insert(live_q.size(), rsp_ch.data_offset);
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_wanted = 0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= 1'b0;
    req_ch.req_bytes   <= '0;
    req_ch.free_offset <= '0;
    sent          = 0;
    hold_wanted   = 0;
    phase         = 0;
    send_idle_pct = 34;
    recv_idle_pct = 82;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: whole pool, double free, bad addresses, no fit, merges
    send_item(1'b0, 0, 0);
    send_item(1'b0, 4095, 0);
    send_item(1'b0, POOL_USED - HDR, 0);
    send_item(1'b1, 0, HDR);
    send_item(1'b1, 0, HDR);
    send_item(1'b1, 0, 0);
    send_item(1'b1, 0, HDR + 1);
    send_item(1'b1, 0, 4095);
    send_item(1'b1, 0, HDR + 8);
    send_item(1'b0, 1, 0);
    send_item(1'b0, 9, 0);
    send_item(1'b0, 100, 0);
    send_item(1'b0, 8, 0);
    send_item(1'b1, 0, 72);
    send_item(1'b1, 0, 32);
    send_item(1'b1, 0, 120);
    send_item(1'b0, 4000, 0);
    send_item(1'b0, 2048, 0);
    send_item(1'b0, 1, 0);
    send_item(1'b1, 0, 2048 + HDR + 2048 - 1);
    send_item(1'b0, 4095, 0);

    while (sent < ITEMS) begin
      if (phase == 0 && sent >= ITEMS / 3) begin
        wait_drained();
        phase = 1;
        send_idle_pct = 82;
        recv_idle_pct = 34;
      end else if (phase == 1 && sent >= 2 * ITEMS / 3) begin
        wait_drained();
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_wanted = 1;
      end
      send_random();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
